/* src/pdes_pkg.sv */
package pdes_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int DRAG_BITS      = 24;
    localparam int DRAG_SHIFT     = 24;

    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_TIME   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DRAG_FACTOR = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_X    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_Y    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE   = 3'd4;

    localparam logic CMD_LAUNCH = 1'b0;
    localparam logic CMD_STEP   = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_MUL_VXX,
        OP_MUL_VYY,
        OP_SQ_INIT,
        OP_SQRT_STEP,
        OP_MUL_KS,
        OP_K,
        OP_MUL_KDT,
        OP_KDT,
        OP_MUL_DX,
        OP_DX,
        OP_MUL_DY,
        OP_DY,
        OP_MUL_G,
        OP_G,
        OP_VEL,
        OP_MUL_PX,
        OP_PX,
        OP_MUL_PY,
        OP_PY,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   command;
    } dp_cmd_t;

endpackage

/* src/pdes_if.sv */
interface pdes_cmd_if #(parameter int WORD_BITS = 32);
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [WORD_BITS-1:0] launch_vx;
    logic [WORD_BITS-1:0] launch_vy;

    modport source (output valid, command, launch_vx, launch_vy, input ready);
    modport sink (input valid, command, launch_vx, launch_vy, output ready);
endinterface

interface pdes_res_if #(parameter int WORD_BITS = 32);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] position_x;
    logic [WORD_BITS-1:0] position_y;
    logic [WORD_BITS-1:0] velocity_x;
    logic [WORD_BITS-1:0] velocity_y;
    logic                 target_hit;
    logic                 below_ground;

    modport source (output valid, position_x, position_y, velocity_x, velocity_y,
                    target_hit, below_ground, input ready);
    modport sink (input valid, position_x, position_y, velocity_x, velocity_y,
                  target_hit, below_ground, output ready);
endinterface

interface pdes_cfg_if #(parameter int WORD_BITS = 32);
    logic                                valid;
    logic                                ready;
    logic [pdes_pkg::CFG_INDEX_BITS-1:0] index;
    logic [WORD_BITS-1:0]                data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/pdes_ctrl.sv */
module pdes_ctrl #(
    parameter int WORD_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_command,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    output pdes_pkg::dp_cmd_t dp_cmd
);

    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_MVXX, S_MVYY, S_SQI, S_SQS, S_MKS, S_K, S_MKDT, S_KDT,
        S_MDX, S_DX, S_MDY, S_DY, S_MG, S_G, S_VEL, S_MPX, S_PX, S_MPY, S_PY, S_FIN
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic                accept;
    logic                emit;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign emit      = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        dp_cmd.command = in_command;
        unique case (state_reg)
            S_IDLE:  dp_cmd.op = accept ? pdes_pkg::OP_ACCEPT : pdes_pkg::OP_NONE;
            S_MVXX:  dp_cmd.op = pdes_pkg::OP_MUL_VXX;
            S_MVYY:  dp_cmd.op = pdes_pkg::OP_MUL_VYY;
            S_SQI:   dp_cmd.op = pdes_pkg::OP_SQ_INIT;
            S_SQS:   dp_cmd.op = pdes_pkg::OP_SQRT_STEP;
            S_MKS:   dp_cmd.op = pdes_pkg::OP_MUL_KS;
            S_K:     dp_cmd.op = pdes_pkg::OP_K;
            S_MKDT:  dp_cmd.op = pdes_pkg::OP_MUL_KDT;
            S_KDT:   dp_cmd.op = pdes_pkg::OP_KDT;
            S_MDX:   dp_cmd.op = pdes_pkg::OP_MUL_DX;
            S_DX:    dp_cmd.op = pdes_pkg::OP_DX;
            S_MDY:   dp_cmd.op = pdes_pkg::OP_MUL_DY;
            S_DY:    dp_cmd.op = pdes_pkg::OP_DY;
            S_MG:    dp_cmd.op = pdes_pkg::OP_MUL_G;
            S_G:     dp_cmd.op = pdes_pkg::OP_G;
            S_VEL:   dp_cmd.op = pdes_pkg::OP_VEL;
            S_MPX:   dp_cmd.op = pdes_pkg::OP_MUL_PX;
            S_PX:    dp_cmd.op = pdes_pkg::OP_PX;
            S_MPY:   dp_cmd.op = pdes_pkg::OP_MUL_PY;
            S_PY:    dp_cmd.op = pdes_pkg::OP_PY;
            S_FIN:   dp_cmd.op = emit ? pdes_pkg::OP_EMIT : pdes_pkg::OP_NONE;
            default: dp_cmd.op = pdes_pkg::OP_NONE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (in_command == pdes_pkg::CMD_STEP) ? S_MVXX : S_FIN;
            end
            S_MVXX:  state_next = S_MVYY;
            S_MVYY:  state_next = S_SQI;
            S_SQI:
            begin
                state_next = S_SQS;
                cnt_next   = '0;
            end
            S_SQS:
            begin
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(WORD_BITS - 1))
                    state_next = S_MKS;
            end
            S_MKS:   state_next = S_K;
            S_K:     state_next = S_MKDT;
            S_MKDT:  state_next = S_KDT;
            S_KDT:   state_next = S_MDX;
            S_MDX:   state_next = S_DX;
            S_DX:    state_next = S_MDY;
            S_MDY:   state_next = S_DY;
            S_DY:    state_next = S_MG;
            S_MG:    state_next = S_G;
            S_G:     state_next = S_VEL;
            S_VEL:   state_next = S_MPX;
            S_MPX:   state_next = S_PX;
            S_PX:    state_next = S_MPY;
            S_MPY:   state_next = S_PY;
            S_PY:    state_next = S_FIN;
            S_FIN:
            begin
                if (emit)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/pdes_dp.sv */
module pdes_dp #(
    parameter int FRACTION_BITS = 16,
    parameter int WORD_BITS     = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pdes_pkg::dp_cmd_t                   ctl,
    input  logic [WORD_BITS-1:0]                launch_vx,
    input  logic [WORD_BITS-1:0]                launch_vy,
    input  logic                                cfg_we,
    input  logic [pdes_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]                cfg_data,
    output logic [WORD_BITS-1:0]                position_x,
    output logic [WORD_BITS-1:0]                position_y,
    output logic [WORD_BITS-1:0]                velocity_x,
    output logic [WORD_BITS-1:0]                velocity_y,
    output logic                                target_hit,
    output logic                                below_ground
);

    localparam int W = WORD_BITS;
    localparam int F = FRACTION_BITS;
    localparam int P = 2 * W + 1;

    localparam logic [63:0] STEP_RST64 = ((64'd3 << F) + 64'd50) / 64'd100;
    localparam logic [63:0] TX_RST64   = 64'd1000 << F;
    localparam logic [63:0] TY_RST64   = 64'd300 << F;
    localparam logic [63:0] TOL_RST64  = 64'd6 << F;
    localparam logic [63:0] GRAV64     = ((64'd196 << F) + 64'd10) / 64'd20;
    localparam logic [W-1:0] WORD_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] GRAVITY   = GRAV64[W-1:0];

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (~v + W'(1)) : v;
    endfunction

    function automatic logic [W-1:0] sat_mag(input logic [P-1:0] v);
        sat_mag = (v > P'(WORD_MAX)) ? WORD_MAX : v[W-1:0];
    endfunction

    // clamp a sum carrying two guard bits to the signed word range
    function automatic logic [W-1:0] clamp_word(input logic [W+1:0] v);
        logic ovf;
        ovf = !((v[W+1:W-1] == 3'b000) || (v[W+1:W-1] == 3'b111));
        if (!ovf)
            clamp_word = v[W-1:0];
        else if (v[W+1])
            clamp_word = {1'b1, {(W-1){1'b0}}};
        else
            clamp_word = WORD_MAX;
    endfunction

    function automatic logic [W+1:0] apply_sign(input logic [W-1:0] m, input logic neg);
        apply_sign = neg ? (~{2'b00, m} + (W+2)'(1)) : {2'b00, m};
    endfunction

    function automatic logic inside_box(input logic [W-1:0] p, input logic [W-1:0] c,
                                        input logic [W-2:0] t);
        logic signed [W+1:0] pe, ce, te;
        pe = {{2{p[W-1]}}, p};
        ce = {{2{c[W-1]}}, c};
        te = {3'b000, t};
        inside_box = (pe > ce - te) && (pe < ce + te);
    endfunction

    // configuration
    logic [F-1:0]                  step_reg;
    logic [pdes_pkg::DRAG_BITS-1:0] drag_reg;
    logic [W-1:0]                  tx_reg, ty_reg;
    logic [W-2:0]                  tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RST64[F-1:0];
            drag_reg <= pdes_pkg::DRAG_BITS'(23255);
            tx_reg   <= TX_RST64[W-1:0];
            ty_reg   <= TY_RST64[W-1:0];
            tol_reg  <= TOL_RST64[W-2:0];
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pdes_pkg::REG_STEP_TIME:   step_reg <= cfg_data[F-1:0];
                pdes_pkg::REG_DRAG_FACTOR: drag_reg <= cfg_data[pdes_pkg::DRAG_BITS-1:0];
                pdes_pkg::REG_TARGET_X:    tx_reg   <= cfg_data;
                pdes_pkg::REG_TARGET_Y:    ty_reg   <= cfg_data;
                pdes_pkg::REG_TOLERANCE:   tol_reg  <= cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // state
    logic [W-1:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic [W-1:0] pos_x_next, pos_y_next, vel_x_next, vel_y_next;

    // work registers
    logic [2*W-1:0] prod_reg, sum_reg, rad_reg;
    logic [W:0]     rem_reg;
    logic [W-1:0]   root_reg;
    logic [W-1:0]   k_reg, kdt_reg, dx_reg, dy_reg, g_reg;
    logic [W-1:0]   a_mux, b_mux;
    logic [W-1:0]   speed;
    logic [P-1:0]   rnd_drag, rnd_frac;
    logic [W-1:0]   rmag;
    logic [W+2:0]   rem_sh, trial, rem_diff;
    logic [W+1:0]   vx_full, vy_full, px_full, py_full;

    assign speed = (root_reg > WORD_MAX) ? WORD_MAX : root_reg;

    always_comb
    begin
        case (ctl.op)
            pdes_pkg::OP_MUL_VXX:
            begin
                a_mux = mag(vel_x_reg);
                b_mux = mag(vel_x_reg);
            end
            pdes_pkg::OP_MUL_VYY:
            begin
                a_mux = mag(vel_y_reg);
                b_mux = mag(vel_y_reg);
            end
            pdes_pkg::OP_MUL_KS:
            begin
                a_mux = W'(drag_reg);
                b_mux = speed;
            end
            pdes_pkg::OP_MUL_KDT:
            begin
                a_mux = k_reg;
                b_mux = W'(step_reg);
            end
            pdes_pkg::OP_MUL_DX:
            begin
                a_mux = kdt_reg;
                b_mux = mag(vel_x_reg);
            end
            pdes_pkg::OP_MUL_DY:
            begin
                a_mux = kdt_reg;
                b_mux = mag(vel_y_reg);
            end
            pdes_pkg::OP_MUL_G:
            begin
                a_mux = GRAVITY;
                b_mux = W'(step_reg);
            end
            pdes_pkg::OP_MUL_PX:
            begin
                a_mux = mag(vel_x_reg);
                b_mux = W'(step_reg);
            end
            pdes_pkg::OP_MUL_PY:
            begin
                a_mux = mag(vel_y_reg);
                b_mux = W'(step_reg);
            end
            default:
            begin
                a_mux = '0;
                b_mux = '0;
            end
        endcase
    end

    // round half up on the magnitude, then saturate
    assign rnd_drag = ({1'b0, prod_reg} + (P'(1) << (pdes_pkg::DRAG_SHIFT - 1)))
                      >> pdes_pkg::DRAG_SHIFT;
    assign rnd_frac = ({1'b0, prod_reg} + (P'(1) << (F - 1))) >> F;
    assign rmag     = sat_mag((ctl.op == pdes_pkg::OP_K) ? rnd_drag : rnd_frac);

    // one result bit of the square root per cycle
    assign rem_sh   = {rem_reg, rad_reg[2*W-1 -: 2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign rem_diff = rem_sh - trial;

    assign vx_full = {{2{vel_x_reg[W-1]}}, vel_x_reg} - apply_sign(dx_reg, vel_x_reg[W-1]);
    assign vy_full = {{2{vel_y_reg[W-1]}}, vel_y_reg} - apply_sign(dy_reg, vel_y_reg[W-1])
                     - {2'b00, g_reg};
    assign px_full = {{2{pos_x_reg[W-1]}}, pos_x_reg} + apply_sign(rmag, vel_x_reg[W-1]);
    assign py_full = {{2{pos_y_reg[W-1]}}, pos_y_reg} + apply_sign(rmag, vel_y_reg[W-1]);

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        vel_x_next = vel_x_reg;
        vel_y_next = vel_y_reg;
        case (ctl.op)
            pdes_pkg::OP_ACCEPT:
            begin
                if (ctl.command == pdes_pkg::CMD_LAUNCH)
                begin
                    pos_x_next = '0;
                    pos_y_next = '0;
                    vel_x_next = launch_vx;
                    vel_y_next = launch_vy;
                end
            end
            pdes_pkg::OP_VEL:
            begin
                vel_x_next = clamp_word(vx_full);
                vel_y_next = clamp_word(vy_full);
            end
            pdes_pkg::OP_PX: pos_x_next = clamp_word(px_full);
            pdes_pkg::OP_PY: pos_y_next = clamp_word(py_full);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            vel_x_reg <= '0;
            vel_y_reg <= '0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            vel_x_reg <= vel_x_next;
            vel_y_reg <= vel_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_mux * b_mux;
        case (ctl.op)
            pdes_pkg::OP_MUL_VYY: sum_reg <= prod_reg;
            pdes_pkg::OP_SQ_INIT:
            begin
                rad_reg  <= sum_reg + prod_reg;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            pdes_pkg::OP_SQRT_STEP:
            begin
                rad_reg <= {rad_reg[2*W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_diff[W:0];
                    root_reg <= {root_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh[W:0];
                    root_reg <= {root_reg[W-2:0], 1'b0};
                end
            end
            pdes_pkg::OP_K:   k_reg   <= rmag;
            pdes_pkg::OP_KDT: kdt_reg <= rmag;
            pdes_pkg::OP_DX:  dx_reg  <= rmag;
            pdes_pkg::OP_DY:  dy_reg  <= rmag;
            pdes_pkg::OP_G:   g_reg   <= rmag;
            pdes_pkg::OP_EMIT:
            begin
                position_x   <= pos_x_reg;
                position_y   <= pos_y_reg;
                velocity_x   <= vel_x_reg;
                velocity_y   <= vel_y_reg;
                target_hit   <= inside_box(pos_x_reg, tx_reg, tol_reg)
                                && inside_box(pos_y_reg, ty_reg, tol_reg);
                below_ground <= pos_y_reg[W-1];
            end
            default: ;
        endcase
    end

endmodule

/* src/projectile_drag_euler_step_core.sv */
// Euler integrator for a point projectile under gravity and quadratic drag, in signed
// fixed point (WORD_BITS wide, FRACTION_BITS fraction bits). A launch word loads the
// velocity and zeroes the position; a step word advances one time step. Every word
// returns one result word with the new state and the target and ground flags. Words are
// processed one at a time: a launch goes straight to its result, and a step is paced by
// the bit-serial square root for the speed (one result bit per cycle) and by the single
// shared multiplier, whose product is registered before rounding. The next command word
// is taken while a result still waits on the output. Configuration writes are always
// accepted and take effect at once, so write them only while no word is in flight.
module projectile_drag_euler_step_core #(
    parameter int FRACTION_BITS = 16,
    parameter int WORD_BITS     = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    pdes_cmd_if.sink   cmd,
    pdes_res_if.source res,
    pdes_cfg_if.sink   cfg
);

    pdes_pkg::dp_cmd_t dp_cmd;

    assign cfg.ready = 1'b1;

    pdes_ctrl #(
        .WORD_BITS(WORD_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd.valid),
        .in_command (cmd.command),
        .in_ready   (cmd.ready),
        .out_ready  (res.ready),
        .out_valid  (res.valid),
        .dp_cmd     (dp_cmd)
    );

    pdes_dp #(
        .FRACTION_BITS(FRACTION_BITS),
        .WORD_BITS    (WORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (dp_cmd),
        .launch_vx    (cmd.launch_vx),
        .launch_vy    (cmd.launch_vy),
        .cfg_we       (cfg.valid && cfg.ready),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .position_x   (res.position_x),
        .position_y   (res.position_y),
        .velocity_x   (res.velocity_x),
        .velocity_y   (res.velocity_y),
        .target_hit   (res.target_hit),
        .below_ground (res.below_ground)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("command accepted while busy");

    a_ground_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.below_ground == res.position_y[WORD_BITS-1])
        else $error("below_ground disagrees with position_y");

    a_launch_origin: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready && (cmd.command == pdes_pkg::CMD_LAUNCH) && !res.valid
        |-> ##2 (res.valid && (res.position_x == '0) && (res.position_y == '0)
                 && !res.below_ground))
        else $error("launch result not at origin");
`endif

endmodule

/* tb/pdes_tb_if.sv */
`timescale 1ns / 100ps

// the block's channel interfaces live in src/pdes_if.sv; nothing extra is needed here
package pdes_tb_pkg;
    localparam int W = 32;
    localparam int F = 16;
    localparam logic [63:0] GRAVITY_RAW = (196 * (64'd1 << F) + 10) / 20;
endpackage

/* tb/projectile_drag_euler_step_core_tb.sv */
`timescale 1ns / 100ps

module projectile_drag_euler_step_core_tb;

    localparam int W = pdes_tb_pkg::W;
    localparam int F = pdes_tb_pkg::F;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [W-1:0] px;
        logic [W-1:0] py;
        logic [W-1:0] vx;
        logic [W-1:0] vy;
        logic         hit;
        logic         below;
    } flight_state_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pdes_cmd_if #(.WORD_BITS(W)) cmd();
    pdes_res_if #(.WORD_BITS(W)) res();
    pdes_cfg_if #(.WORD_BITS(W)) cfg();

    projectile_drag_euler_step_core #(.FRACTION_BITS(F), .WORD_BITS(W)) dut (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .res(res), .cfg(cfg)
    );

    always #2 clk = ~clk;

    // predictor copy of registers and flight state
    logic [63:0] dt_q, drag_q, tol_q;
    longint tgt_x, tgt_y, pos_x, pos_y, vel_x, vel_y;

    flight_state_t flight_q[$];
    int errors = 0;
    int launches = 0;
    int steps = 0;
    int results = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit hold_off = 1'b0;
    bit stall_rand = 1'b1;

    localparam longint WMAX = (64'sd1 <<< (W - 1)) - 1;
    localparam longint WMIN = -WMAX - 1;

    function automatic longint clamp_word(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] round_mul(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = 128'(a) * 128'(b) + (128'd1 << (sh - 1));
        p = p >> sh;
        return p > 128'(WMAX) ? 64'(WMAX) : p[63:0];
    endfunction

    function automatic logic [63:0] speed_root(longint a, longint b);
        logic [127:0] n;
        logic [127:0] c;
        logic [63:0] r;
        n = 128'(magnitude(a)) * magnitude(a) + 128'(magnitude(b)) * magnitude(b);
        r = 0;
        for (int i = 49; i >= 0; i--)
        begin
            c = 128'(r | (64'd1 << i));
            if (c * c <= n) r = c[63:0];
        end
        return r > 64'(WMAX) ? 64'(WMAX) : r;
    endfunction

    function automatic longint apply_sign(logic [63:0] m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic bit in_span(longint p, longint c);
        return p > c - longint'(tol_q) && p < c + longint'(tol_q);
    endfunction

    function automatic longint sext_word(logic [W-1:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic flight_state_t advance_flight(bit command, logic [W-1:0] lvx,
                                                     logic [W-1:0] lvy);
        logic [63:0] s, k, kdt, g;
        longint dx, dy;
        flight_state_t r;
        if (command == pdes_pkg::CMD_LAUNCH)
        begin
            pos_x = 0;
            pos_y = 0;
            vel_x = sext_word(lvx);
            vel_y = sext_word(lvy);
        end
        else
        begin
            s = speed_root(vel_x, vel_y);
            k = round_mul(drag_q, s, pdes_pkg::DRAG_SHIFT);
            kdt = round_mul(k, dt_q, F);
            dx = apply_sign(round_mul(kdt, magnitude(vel_x), F), vel_x < 0);
            dy = apply_sign(round_mul(kdt, magnitude(vel_y), F), vel_y < 0);
            g = round_mul(pdes_tb_pkg::GRAVITY_RAW, dt_q, F);
            vel_x = clamp_word(vel_x - dx);
            vel_y = clamp_word(vel_y - dy - longint'(g));
            pos_x = clamp_word(pos_x + apply_sign(round_mul(magnitude(vel_x), dt_q, F),
                                                  vel_x < 0));
            pos_y = clamp_word(pos_y + apply_sign(round_mul(magnitude(vel_y), dt_q, F),
                                                  vel_y < 0));
        end
        r.px = pos_x[W-1:0];
        r.py = pos_y[W-1:0];
        r.vx = vel_x[W-1:0];
        r.vy = vel_y[W-1:0];
        r.hit = in_span(pos_x, tgt_x) && in_span(pos_y, tgt_y);
        r.below = pos_y < 0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results);
    endtask

    // result side: random stalls, occasional long stalls, long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_off)
            res.ready <= 1'b0;
        else if (!stall_rand)
            res.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            res.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) == 0)
        begin
            res.ready <= 1'b0;
            stall_left <= $urandom_range(20, 80);
        end
        else
            res.ready <= ($urandom_range(0, 9) < 7);
    end

    always @(posedge clk)
    begin
        flight_state_t want;
        if (rst_n && res.valid && res.ready)
        begin
            results++;
            if (flight_q.size() == 0)
            begin
                errors++;
                $display("unexpected result word %0d", results);
            end
            else
            begin
                want = flight_q.pop_front();
                if (res.position_x !== want.px)
                    report_mismatch("position_x", res.position_x, want.px);
                if (res.position_y !== want.py)
                    report_mismatch("position_y", res.position_y, want.py);
                if (res.velocity_x !== want.vx)
                    report_mismatch("velocity_x", res.velocity_x, want.vx);
                if (res.velocity_y !== want.vy)
                    report_mismatch("velocity_y", res.velocity_y, want.vy);
                if (res.target_hit !== want.hit)
                    report_mismatch("target_hit", res.target_hit, want.hit);
                if (res.below_ground !== want.below)
                    report_mismatch("below_ground", res.below_ground, want.below);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("projectile_drag_euler_step_core_tb: done, errors");
            $finish;
        end
    end

    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 99) < 85 ? $urandom_range(0, 3) : $urandom_range(10, 80);
        repeat (n) @(posedge clk);
    endtask

    // valid stays up after a word so that words can follow back to back
    task automatic send_word(bit command, logic [W-1:0] lvx, logic [W-1:0] lvy, bit gaps);
        cfg.valid <= 1'b0;
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
            idle_gap();
        end
        cmd.valid <= 1'b1;
        cmd.command <= command;
        cmd.launch_vx <= lvx;
        cmd.launch_vy <= lvy;
        do @(posedge clk); while (!cmd.ready);
        flight_q.push_back(advance_flight(command, lvx, lvy));
        if (command == pdes_pkg::CMD_LAUNCH) launches++; else steps++;
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        cfg.valid <= 1'b0;
        while (flight_q.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(logic [pdes_pkg::CFG_INDEX_BITS-1:0] idx, logic [W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            pdes_pkg::REG_STEP_TIME:   dt_q = value & ((64'd1 << F) - 1);
            pdes_pkg::REG_DRAG_FACTOR: drag_q = value & 64'hFF_FFFF;
            pdes_pkg::REG_TARGET_X:    tgt_x = sext_word(value);
            pdes_pkg::REG_TARGET_Y:    tgt_y = sext_word(value);
            pdes_pkg::REG_TOLERANCE:   tol_q = value & ((64'd1 << (W - 1)) - 1);
            default: ;
        endcase
    endtask

    function automatic logic [W-1:0] rand_vel();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return W'(32'h7FFF_FFFF);
            2: return W'(32'h8000_0000);
            default: return W'(signed'($urandom_range(0, 200 << F)) - (100 << F));
        endcase
    endfunction

    task automatic test_directed();
        // step from rest: zero speed
        send_word(pdes_pkg::CMD_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_word(pdes_pkg::CMD_LAUNCH, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        repeat (3) send_word(pdes_pkg::CMD_STEP, 0, 0, 0);
        send_word(pdes_pkg::CMD_LAUNCH, 32'h8000_0000, 32'h8000_0000, 0);
        repeat (3) send_word(pdes_pkg::CMD_STEP, 0, 0, 0);
        send_word(pdes_pkg::CMD_LAUNCH, 0, 0, 0);
        send_word(pdes_pkg::CMD_STEP, 0, 0, 0);
        send_word(pdes_pkg::CMD_LAUNCH, 300 << F, 100 << F, 0);
        repeat (6) send_word(pdes_pkg::CMD_STEP, $urandom(), $urandom(), 0);
        drain();
        write_reg(pdes_pkg::REG_STEP_TIME, 32'hFFFF);
        write_reg(pdes_pkg::REG_DRAG_FACTOR, 32'hFF_FFFF);
        write_reg(pdes_pkg::REG_TOLERANCE, 32'hFFFF_FFFF);
        write_reg(pdes_pkg::REG_TARGET_X, 32'h8000_0000);
        write_reg(pdes_pkg::REG_TARGET_Y, 32'h7FFF_FFFF);
        send_word(pdes_pkg::CMD_LAUNCH, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        repeat (3) send_word(pdes_pkg::CMD_STEP, 0, 0, 0);
        drain();
        write_reg(pdes_pkg::REG_STEP_TIME, 0);
        write_reg(pdes_pkg::REG_DRAG_FACTOR, 0);
        write_reg(pdes_pkg::REG_TARGET_X, 0);
        write_reg(pdes_pkg::REG_TARGET_Y, 0);
        write_reg(pdes_pkg::REG_TOLERANCE, 0);
        write_reg(3'd7, 32'hFFFF_FFFF);   // out-of-range index is ignored
        send_word(pdes_pkg::CMD_LAUNCH, 5 << F, 32'hFFFF_0000, 0);
        send_word(pdes_pkg::CMD_STEP, 0, 0, 0);
        drain();
    endtask

    task automatic test_flights(int words);
        int sent;
        int len;
        sent = 0;
        while (sent < words)
        begin
            send_word(pdes_pkg::CMD_LAUNCH, rand_vel(), rand_vel(), 1);
            len = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12);
            repeat (len) send_word(pdes_pkg::CMD_STEP, $urandom(), $urandom(), 1);
            sent += len + 1;
        end
    endtask

    task automatic test_settings();
        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            write_reg(pdes_pkg::REG_STEP_TIME, phase == 0 ? 1 : $urandom_range(0, 65535));
            write_reg(pdes_pkg::REG_DRAG_FACTOR,
                      phase == 1 ? 32'hFF_FFFF : $urandom_range(0, 200000));
            // target near the typical flight so hits happen
            write_reg(pdes_pkg::REG_TARGET_X, $urandom_range(0, 40 << F));
            write_reg(pdes_pkg::REG_TARGET_Y, $urandom_range(0, 10 << F));
            write_reg(pdes_pkg::REG_TOLERANCE,
                      phase == 2 ? $urandom() : $urandom_range(0, 50 << F));
            test_flights(150);
        end
    endtask

    task automatic test_backpressure();
        drain();
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                send_word(pdes_pkg::CMD_LAUNCH, 20 << F, 20 << F, 0);
                repeat (6) send_word(pdes_pkg::CMD_STEP, 0, 0, 0);
            end
        join
        drain();
        stall_rand = 1'b0;
        test_flights(60);
        stall_rand = 1'b1;
        drain();
    endtask

    initial
    begin
        cmd.valid = 1'b0;
        cmd.command = pdes_pkg::CMD_LAUNCH;
        cmd.launch_vx = '0;
        cmd.launch_vy = '0;
        cfg.valid = 1'b0;
        cfg.index = pdes_pkg::REG_STEP_TIME;
        cfg.data = '0;
        dt_q = (3 * (64'd1 << F) + 50) / 100;
        drag_q = 23255;
        tgt_x = 1000 <<< F;
        tgt_y = 300 <<< F;
        tol_q = 6 << F;
        pos_x = 0;
        pos_y = 0;
        vel_x = 0;
        vel_y = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_settings();
        drain();
        $display("covered %0d launch and %0d step words, %0d results, saturation and zero-speed",
                 launches, steps, results);
        $display("settings swept from zero to full scale with random and long output stalls");
        if (errors == 0)
            $display("projectile_drag_euler_step_core_tb: done, clean");
        else
            $display("projectile_drag_euler_step_core_tb: done, errors");
        $finish;
    end
endmodule
